// ===== sv/alkd_pkg.sv =====
// Shared types, widths and register codes for the ADC ladder key decoder.
// No dependencies; every other file of the block imports this package.
package alkd_pkg;

    localparam int SAMPLE_W        = 12;
    localparam int MAX_KEYS        = 4;
    localparam int KEY_W           = 2;
    localparam int CFG_IDX_W       = 3;
    localparam int AVG_SAMPLES_DEF = 10;
    localparam int NUM_KEYS_DEF    = 4;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [MAX_KEYS-1:0] key_mask_t;
    typedef logic [KEY_W-1:0]    key_idx_t;
    typedef sample_t [MAX_KEYS-1:0] key_upper_t;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_NO_KEY_LEVEL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY0_UPPER   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY1_UPPER   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY2_UPPER   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KEY3_UPPER   = 3'd4;

    // Reset values of the registers
    localparam sample_t NO_KEY_LEVEL_RST = 12'd300;
    localparam sample_t KEY0_UPPER_RST   = 12'd33;
    localparam sample_t KEY1_UPPER_RST   = 12'd111;
    localparam sample_t KEY2_UPPER_RST   = 12'd206;
    localparam sample_t KEY3_UPPER_RST   = 12'd280;

    // Event passed down the pipe: release, or a finished average block
    typedef struct packed {
        logic valid;
        logic release_ev;
    } ev_ctrl_t;

endpackage

// ===== sv/alkd_accum.sv =====
// Input register and running-sum accumulator of the ADC ladder key decoder.
// Depends on alkd_pkg; emits release and block-sum events.
module alkd_accum
    import alkd_pkg::*;
#(
    parameter int AVG_SAMPLES = AVG_SAMPLES_DEF,
    parameter int SUM_W       = SAMPLE_W + $clog2(AVG_SAMPLES)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  sample_t          s_sample,
    input  sample_t          no_key_level,
    output ev_ctrl_t         ev_out,
    output logic [SUM_W-1:0] ev_sum,
    input  logic             ev_ready
);

    localparam int CNT_W = $clog2(AVG_SAMPLES);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(AVG_SAMPLES - 1);

    logic             in_valid_reg, in_valid_next;
    sample_t          in_sample_reg;
    logic [SUM_W-1:0] sum_reg, sum_next, sum_add;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ev_valid_reg, ev_valid_next;
    logic             ev_release_reg, ev_release_next;
    logic [SUM_W-1:0] ev_sum_reg, ev_sum_next;
    logic             consume, above, emit;

    assign consume = in_valid_reg && (!ev_valid_reg || ev_ready);
    assign s_ready = !in_valid_reg || consume;
    assign above   = in_sample_reg > no_key_level;
    assign sum_add = sum_reg + SUM_W'(in_sample_reg);

    always_comb begin
        in_valid_next   = in_valid_reg;
        sum_next        = sum_reg;
        count_next      = count_reg;
        emit            = 1'b0;
        ev_release_next = ev_release_reg;
        ev_sum_next     = ev_sum_reg;
        if (consume) begin
            in_valid_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end
        if (consume) begin
            if (above) begin
                sum_next        = '0;
                count_next      = '0;
                emit            = 1'b1;
                ev_release_next = 1'b1;
            end else if (count_reg == CNT_LAST) begin
                sum_next        = '0;
                count_next      = '0;
                emit            = 1'b1;
                ev_release_next = 1'b0;
                ev_sum_next     = sum_add;
            end else begin
                sum_next   = sum_add;
                count_next = count_reg + 1'b1;
            end
        end
        ev_valid_next = consume ? emit : (ev_valid_reg && !ev_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            sum_reg      <= '0;
            count_reg    <= '0;
            ev_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            sum_reg      <= sum_next;
            count_reg    <= count_next;
            ev_valid_reg <= ev_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_sample_reg <= s_sample;
        end
        ev_release_reg <= ev_release_next;
        ev_sum_reg     <= ev_sum_next;
    end

    assign ev_out.valid      = ev_valid_reg;
    assign ev_out.release_ev = ev_release_reg;
    assign ev_sum            = ev_sum_reg;

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_LAST)
        else $error("sample count past block length");

    a_release_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (consume && above) |=> (count_reg == '0 && sum_reg == '0))
        else $error("release did not restart the block");

endmodule

// ===== sv/alkd_divide.sv =====
// Block-average stage: divides the block sum by the block length with an exact
// reciprocal multiply. Depends on alkd_pkg.
module alkd_divide
    import alkd_pkg::*;
#(
    parameter int AVG_SAMPLES = AVG_SAMPLES_DEF,
    parameter int SUM_W       = SAMPLE_W + $clog2(AVG_SAMPLES)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  ev_ctrl_t         ev_in,
    input  logic [SUM_W-1:0] ev_sum,
    output logic             ev_ready,
    output ev_ctrl_t         q_out,
    output sample_t          q_avg,
    input  logic             q_ready
);

    // Exact for any sum below 2**SUM_W: m = ceil(2**(SUM_W+l) / d), l = ceil(log2 d)
    localparam int SHIFT   = SUM_W + $clog2(AVG_SAMPLES);
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(AVG_SAMPLES) - 64'd1) / 64'(AVG_SAMPLES);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

    logic [PROD_W-1:0] prod;
    logic              fire;
    logic              q_valid_reg, q_valid_next;
    logic              q_release_reg;
    sample_t           q_avg_reg;

    assign prod     = PROD_W'(ev_sum) * PROD_W'(RECIP);
    assign ev_ready = !q_valid_reg || q_ready;
    assign fire     = ev_in.valid && ev_ready;

    always_comb begin
        q_valid_next = fire ? 1'b1 : (q_valid_reg && !q_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_valid_reg <= 1'b0;
        end else begin
            q_valid_reg <= q_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            q_release_reg <= ev_in.release_ev;
            q_avg_reg     <= prod[SHIFT +: SAMPLE_W];
        end
    end

    assign q_out.valid      = q_valid_reg;
    assign q_out.release_ev = q_release_reg;
    assign q_avg            = q_avg_reg;

endmodule

// ===== sv/alkd_match.sv =====
// Window match, pressed-flag latch and result register of the key decoder.
// Depends on alkd_pkg; consumes release and average events.
module alkd_match
    import alkd_pkg::*;
#(
    parameter int NUM_KEYS = NUM_KEYS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  ev_ctrl_t   q_in,
    input  sample_t    q_avg,
    output logic       q_ready,
    input  key_upper_t key_upper,
    output logic       m_valid,
    input  logic       m_ready,
    output key_idx_t   m_key_index,
    output key_mask_t  m_pressed_mask
);

    localparam key_mask_t KEY_EN = MAX_KEYS'((1 << NUM_KEYS) - 1);

    sample_t   last_avg_reg, last_avg_next;
    logic      avg_valid_reg, avg_valid_next;
    key_mask_t flags_reg, flags_next;
    logic      m_valid_reg, m_valid_next;
    key_idx_t  key_reg, key_next;
    key_mask_t mask_reg, mask_next;
    logic      fire, hit;
    key_idx_t  hit_idx;
    logic [SAMPLE_W:0] lower;

    assign q_ready = !m_valid_reg || m_ready;
    assign fire    = q_in.valid && q_ready;

    // First key whose window [lower, upper] holds the average
    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        lower   = '0;
        for (int i = 0; i < MAX_KEYS; i++) begin
            if (KEY_EN[i] && !hit && ({1'b0, q_avg} >= lower)
                    && (q_avg <= key_upper[i])) begin
                hit     = 1'b1;
                hit_idx = KEY_W'(i);
            end
            lower = {1'b0, key_upper[i]} + 1'b1;
        end
    end

    always_comb begin
        last_avg_next  = last_avg_reg;
        avg_valid_next = avg_valid_reg;
        flags_next     = flags_reg;
        key_next       = key_reg;
        mask_next      = mask_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        if (fire) begin
            m_valid_next = 1'b0;
            if (q_in.release_ev) begin
                if (avg_valid_reg) begin
                    flags_next     = '0;
                    avg_valid_next = 1'b0;
                end
            end else if (!(avg_valid_reg && q_avg == last_avg_reg)) begin
                last_avg_next  = q_avg;
                avg_valid_next = 1'b1;
                if (hit && !flags_reg[hit_idx]) begin
                    flags_next          = flags_reg;
                    flags_next[hit_idx] = 1'b1;
                    key_next            = hit_idx;
                    mask_next           = flags_next;
                    m_valid_next        = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_avg_reg  <= '0;
            avg_valid_reg <= 1'b0;
            flags_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            last_avg_reg  <= last_avg_next;
            avg_valid_reg <= avg_valid_next;
            flags_reg     <= flags_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg  <= key_next;
        mask_reg <= mask_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_key_index    = key_reg;
    assign m_pressed_mask = mask_reg;

    a_flags_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (flags_reg & ~KEY_EN) == '0)
        else $error("flag set for a key outside the ladder");

    a_result_has_key: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> mask_reg[key_reg])
        else $error("reported key not in its pressed mask");

    a_release_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && q_in.release_ev && avg_valid_reg) |=>
            (flags_reg == '0 && !avg_valid_reg))
        else $error("release after an average left flags set");

endmodule

// ===== sv/adc_ladder_key_decoder.sv =====
// Top level of the ADC ladder key decoder: configuration registers and the
// accumulate / divide / match pipeline. Depends on alkd_pkg and alkd_* modules.
//
// Usage:
//  - s_ channel: one 12-bit ADC reading of the key ladder per beat
//    (s_valid / s_ready). A reading above no_key_level is a release: it
//    restarts the averaging block and, if an average was taken since the
//    last release, clears all pressed flags.
//  - Other readings are summed; every AVG_SAMPLES of them the truncated
//    average is matched against the key windows. A key newly latched gives
//    one m_ beat (m_key_index, m_pressed_mask); most readings give none.
//  - Throughput: one reading per cycle, sustained while m_ready stays high.
//  - Path: the reading that completes a block reaches m_ as a result beat
//    through the input register, block-sum register, average register and
//    match/result register, in that order.
//  - Stall: when m_ready is low the result register holds; the input,
//    block-sum and average registers in front still take beats, and s_ready
//    drops only once the pipe has filled up behind the waiting result.
//  - Reset (aresetn low, synchronous): pipe empties, sum, count, last average
//    and pressed flags clear, registers return to their default windows.
//  - cfg_we / cfg_index / cfg_data write one register per cycle; index 0 is
//    no_key_level, 1..4 key0..key3 upper bounds, other indexes are ignored.
//    Write only while the pipe is idle.
module adc_ladder_key_decoder
    import alkd_pkg::*;
#(
    parameter int AVG_SAMPLES = AVG_SAMPLES_DEF,
    parameter int NUM_KEYS    = NUM_KEYS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  sample_t              s_sample,
    output logic                 m_valid,
    input  logic                 m_ready,
    output key_idx_t             m_key_index,
    output key_mask_t            m_pressed_mask,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  sample_t              cfg_data
);

    // Block sum width: a full block of maximum readings never wraps
    localparam int SUM_W = SAMPLE_W + $clog2(AVG_SAMPLES);

    sample_t    no_key_level_reg;
    key_upper_t key_upper_reg;

    ev_ctrl_t         ev;
    logic [SUM_W-1:0] ev_sum;
    logic             ev_ready;
    ev_ctrl_t         q;
    sample_t          q_avg;
    logic             q_ready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            no_key_level_reg <= NO_KEY_LEVEL_RST;
            key_upper_reg[0] <= KEY0_UPPER_RST;
            key_upper_reg[1] <= KEY1_UPPER_RST;
            key_upper_reg[2] <= KEY2_UPPER_RST;
            key_upper_reg[3] <= KEY3_UPPER_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_NO_KEY_LEVEL: no_key_level_reg <= cfg_data;
                REG_KEY0_UPPER:   key_upper_reg[0] <= cfg_data;
                REG_KEY1_UPPER:   key_upper_reg[1] <= cfg_data;
                REG_KEY2_UPPER:   key_upper_reg[2] <= cfg_data;
                REG_KEY3_UPPER:   key_upper_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Stage 1: input register, running sum, release detect
    alkd_accum #(
        .AVG_SAMPLES (AVG_SAMPLES),
        .SUM_W       (SUM_W)
    ) u_accum (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample     (s_sample),
        .no_key_level (no_key_level_reg),
        .ev_out       (ev),
        .ev_sum       (ev_sum),
        .ev_ready     (ev_ready)
    );

    // Stage 2: block average by reciprocal multiply
    alkd_divide #(
        .AVG_SAMPLES (AVG_SAMPLES),
        .SUM_W       (SUM_W)
    ) u_divide (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ev_in    (ev),
        .ev_sum   (ev_sum),
        .ev_ready (ev_ready),
        .q_out    (q),
        .q_avg    (q_avg),
        .q_ready  (q_ready)
    );

    // Stage 3: window match, flag latch, result register
    alkd_match #(
        .NUM_KEYS (NUM_KEYS)
    ) u_match (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_in           (q),
        .q_avg          (q_avg),
        .q_ready        (q_ready),
        .key_upper      (key_upper_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_key_index    (m_key_index),
        .m_pressed_mask (m_pressed_mask)
    );

endmodule
